// ===== design/twfs_pkg.sv =====
// ----------------------------------------------------------------------------
// twfs_pkg: shared types and constants for the trace window fractional shift
// Field widths, register indexes, reset values and controller/datapath links.
// ----------------------------------------------------------------------------
package twfs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = 8;
   localparam int SHIFT_W    = 16;
   localparam int POS_W      = 6;
   localparam int LEN_W      = 9;
   localparam int CTR_W      = 8;
   localparam int HALF_W     = 5;
   localparam int FRAC_W     = 8;
   localparam int TAP_W      = 14;
   localparam int PROD_W     = SAMPLE_W + 1 + FRAC_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam int DEF_MAX_TRACE       = 256;
   localparam int DEF_MAX_HALF_WINDOW = 31;

   localparam logic [CSR_IDX_W-1:0] REG_TRACE_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_CENTER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_WINDOW   = 2'd2;

   localparam logic [LEN_W-1:0]  RST_TRACE_LENGTH  = 9'd256;
   localparam logic [CTR_W-1:0]  RST_WINDOW_CENTER = 8'd127;
   localparam logic [HALF_W-1:0] RST_HALF_WINDOW   = 5'd15;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SHIFT = 1'b1;

   typedef struct packed {
      logic             load;
      logic             capture;
      logic             issue;
      logic [POS_W-1:0] pos;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic advance;
   } stat_type;

endpackage

// ===== design/twfs_if.sv =====
// ----------------------------------------------------------------------------
// twfs_if: handshake channels of the trace window fractional shift
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface twfs_req_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  req_type;
   logic [twfs_pkg::IDX_W-1:0]            sample_index;
   logic signed [twfs_pkg::SAMPLE_W-1:0]  sample_value;
   logic signed [twfs_pkg::SHIFT_W-1:0]   shift_amount;

   modport source (output valid, req_type, sample_index, sample_value, shift_amount,
                   input ready);
   modport sink   (input valid, req_type, sample_index, sample_value, shift_amount,
                   output ready);
endinterface

interface twfs_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [twfs_pkg::SAMPLE_W-1:0]  out_sample;
   logic [twfs_pkg::POS_W-1:0]            out_position;
   logic                                  last;

   modport source (output valid, out_sample, out_position, last, input ready);
   modport sink   (input valid, out_sample, out_position, last, output ready);
endinterface

interface twfs_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [twfs_pkg::CSR_IDX_W-1:0]        index;
   logic [twfs_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/twfs_ram.sv =====
// ----------------------------------------------------------------------------
// twfs_ram: generic RAM, one write port, two registered read ports
// Read data updates only when the read enable is high.
// ----------------------------------------------------------------------------
module twfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/twfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// twfs_ctrl: request controller
// Accepts load and shift items; after a shift item it steps the tap counter over the window.
// ----------------------------------------------------------------------------
module twfs_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_type,
   input  logic [twfs_pkg::HALF_W-1:0]  h_eff,
   input  twfs_pkg::stat_type           stat,
   output logic                         req_ready,
   output twfs_pkg::cmd_type            cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                        state_ff, state_in;
   logic [twfs_pkg::POS_W-1:0]  k_ff, k_in;
   logic                        accept;
   logic                        at_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign at_last   = (k_ff == {h_eff, 1'b0});

   always_comb begin
      cmd.load    = accept && (req_type == twfs_pkg::REQ_LOAD);
      cmd.capture = accept && (req_type == twfs_pkg::REQ_SHIFT);
      cmd.issue   = (state_ff == ST_RUN) && stat.advance;
      cmd.pos     = k_ff;
      cmd.last    = at_last;
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_RUN;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (stat.advance) begin
               if (at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

endmodule

// ===== design/twfs_dp.sv =====
// ----------------------------------------------------------------------------
// twfs_dp: trace store and interpolation pipeline
// Tap address stage, store read, weight multiply, then the output register.
// ----------------------------------------------------------------------------
module twfs_dp #(
   parameter int MAX_TRACE = twfs_pkg::DEF_MAX_TRACE
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  twfs_pkg::cmd_type                    cmd,
   input  logic [twfs_pkg::IDX_W-1:0]           sample_index,
   input  logic signed [twfs_pkg::SAMPLE_W-1:0] sample_value,
   input  logic signed [twfs_pkg::SHIFT_W-1:0]  shift_amount,
   input  logic [twfs_pkg::LEN_W-1:0]           trace_length,
   input  logic [twfs_pkg::CTR_W-1:0]           window_center,
   input  logic [twfs_pkg::HALF_W-1:0]          h_eff,
   input  logic                                 rsp_ready,
   output twfs_pkg::stat_type                   stat,
   output logic                                 rsp_valid,
   output logic signed [twfs_pkg::SAMPLE_W-1:0] out_sample,
   output logic [twfs_pkg::POS_W-1:0]           out_position,
   output logic                                 last
);

   localparam int AW  = $clog2(MAX_TRACE);
   localparam int SW  = twfs_pkg::SAMPLE_W;
   localparam int TW  = twfs_pkg::TAP_W;
   localparam int FW  = twfs_pkg::FRAC_W;
   localparam int PW  = twfs_pkg::PROD_W;
   localparam int XW  = twfs_pkg::SHIFT_W + 1;

   logic advance;

   // shift decode at accept
   logic signed [XW-1:0] s_ext, mag, whole_sh, rem;
   logic [XW-1:0]        mag_rnd;
   logic [FW-1:0]        whole_mag;
   logic signed [TW-1:0] whole_t, start_in;

   logic signed [TW-1:0] start_ff;
   logic                 dir_pos_ff, dir_neg_ff;
   logic [FW-1:0]        frac_ff;

   always_comb begin
      s_ext     = XW'(shift_amount);
      mag       = s_ext[XW-1] ? -s_ext : s_ext;
      mag_rnd   = XW'(mag) + XW'(128);
      whole_mag = FW'(mag_rnd >> 8);
      whole_sh  = {1'b0, whole_mag, 8'b0};
      if (s_ext[XW-1]) begin
         whole_sh = -whole_sh;
      end
      rem      = s_ext - whole_sh;
      whole_t  = s_ext[XW-1] ? -TW'(whole_mag) : TW'(whole_mag);
      start_in = TW'(window_center) - TW'(h_eff) + whole_t;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff   <= start_in;
         dir_pos_ff <= !rem[XW-1] && (rem != '0);
         dir_neg_ff <= rem[XW-1];
         frac_ff    <= rem[XW-1] ? FW'(-rem) : FW'(rem);
      end
   end

   // tap address stage
   logic signed [TW-1:0] n_eff, j, nb;
   logic                 j_ok, nb_ok;

   always_comb begin
      if (TW'(trace_length) > TW'(MAX_TRACE)) begin
         n_eff = TW'(MAX_TRACE);
      end else begin
         n_eff = TW'(trace_length);
      end
      j = start_ff + TW'(cmd.pos);
      priority if (dir_pos_ff) begin
         nb = j + TW'(1);
      end else if (dir_neg_ff) begin
         nb = j - TW'(1);
      end else begin
         nb = j;
      end
      j_ok  = !j[TW-1] && (j < n_eff);
      nb_ok = (dir_pos_ff || dir_neg_ff) && !nb[TW-1] && (nb < n_eff);
   end

   logic [SW-1:0] rd_a, rd_b;
   logic          wr_en;

   assign wr_en = cmd.load && (TW'(sample_index) < TW'(MAX_TRACE));

   twfs_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_TRACE)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(sample_index)),
      .wr_data   (sample_value),
      .rd_en     (advance),
      .rd_addr_a (j[AW-1:0]),
      .rd_addr_b (nb[AW-1:0]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // read stage
   logic                          p1_valid_ff, p1_last_ff, p1_jok_ff, p1_nbok_ff;
   logic [twfs_pkg::POS_W-1:0]    p1_pos_ff;
   logic [FW-1:0]                 p1_frac_ff;

   // multiply stage
   logic                          p2_valid_ff, p2_last_ff, p2_jok_ff, p2_nbok_ff;
   logic [twfs_pkg::POS_W-1:0]    p2_pos_ff;
   logic signed [SW-1:0]          p2_a_ff;
   logic signed [PW-1:0]          p2_prod_ff;

   logic signed [SW:0]            diff;
   logic signed [PW-1:0]          prod_in;

   assign diff    = $signed({rd_b[SW-1], rd_b}) - $signed({rd_a[SW-1], rd_a});
   assign prod_in = PW'(diff * $signed({1'b0, p1_frac_ff}));

   // output register
   logic                          out_valid_ff, out_last_ff;
   logic [twfs_pkg::POS_W-1:0]    out_pos_ff;
   logic signed [SW-1:0]          out_sample_ff, out_sample_in;
   logic signed [PW-1:0]          step;

   always_comb begin
      step = p2_prod_ff >>> 8;
      if (!p2_jok_ff) begin
         out_sample_in = '0;
      end else if (p2_nbok_ff) begin
         out_sample_in = p2_a_ff + SW'(step);
      end else begin
         out_sample_in = p2_a_ff;
      end
   end

   assign advance      = !out_valid_ff || rsp_ready;
   assign stat.advance = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff  <= cmd.issue;
         p2_valid_ff  <= p1_valid_ff;
         out_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_pos_ff     <= cmd.pos;
         p1_last_ff    <= cmd.last;
         p1_jok_ff     <= j_ok;
         p1_nbok_ff    <= nb_ok;
         p1_frac_ff    <= frac_ff;
         p2_pos_ff     <= p1_pos_ff;
         p2_last_ff    <= p1_last_ff;
         p2_jok_ff     <= p1_jok_ff;
         p2_nbok_ff    <= p1_nbok_ff;
         p2_a_ff       <= rd_a;
         p2_prod_ff    <= prod_in;
         out_pos_ff    <= p2_pos_ff;
         out_last_ff   <= p2_last_ff;
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign out_sample   = out_sample_ff;
   assign out_position = out_pos_ff;
   assign last         = out_last_ff;

endmodule

// ===== design/trace_window_fractional_shift_top.sv =====
// Load item: no response. Shift item: 2h+1 response items, one per cycle while the
// response side is ready; the next item is taken in the cycle after the last tap
// is issued.
// The pipeline stalls as a whole while a response waits.
// Reset (synchronous, active high) restores the registers to length 256,
// center 127, half width 15 and empties the pipeline; the store is not cleared.
// ----------------------------------------------------------------------------
// trace_window_fractional_shift_top: shifted, interpolated trace window
// Register file, controller and datapath with the trace store.
// ----------------------------------------------------------------------------
module trace_window_fractional_shift_top #(
   parameter int MAX_TRACE       = twfs_pkg::DEF_MAX_TRACE,
   parameter int MAX_HALF_WINDOW = twfs_pkg::DEF_MAX_HALF_WINDOW
) (
   input  logic        clock,
   input  logic        reset,
   twfs_req_if.sink    req_bus,
   twfs_rsp_if.source  rsp_bus,
   twfs_csr_if.sink    csr_bus
);

   logic [twfs_pkg::LEN_W-1:0]  trace_length_ff;
   logic [twfs_pkg::CTR_W-1:0]  window_center_ff;
   logic [twfs_pkg::HALF_W-1:0] half_window_ff;
   logic [twfs_pkg::HALF_W-1:0] h_eff;

   twfs_pkg::cmd_type  cmd;
   twfs_pkg::stat_type stat;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_length_ff  <= twfs_pkg::RST_TRACE_LENGTH;
         window_center_ff <= twfs_pkg::RST_WINDOW_CENTER;
         half_window_ff   <= twfs_pkg::RST_HALF_WINDOW;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            twfs_pkg::REG_TRACE_LENGTH:  trace_length_ff  <= csr_bus.data;
            twfs_pkg::REG_WINDOW_CENTER: window_center_ff <= csr_bus.data[twfs_pkg::CTR_W-1:0];
            twfs_pkg::REG_HALF_WINDOW:   half_window_ff   <= csr_bus.data[twfs_pkg::HALF_W-1:0];
            default: ;
         endcase
      end
   end

   assign h_eff = (half_window_ff > twfs_pkg::HALF_W'(MAX_HALF_WINDOW))
                ? twfs_pkg::HALF_W'(MAX_HALF_WINDOW) : half_window_ff;

   twfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_type  (req_bus.req_type),
      .h_eff     (h_eff),
      .stat      (stat),
      .req_ready (req_bus.ready),
      .cmd       (cmd)
   );

   twfs_dp #(
      .MAX_TRACE (MAX_TRACE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sample_index  (req_bus.sample_index),
      .sample_value  (req_bus.sample_value),
      .shift_amount  (req_bus.shift_amount),
      .trace_length  (trace_length_ff),
      .window_center (window_center_ff),
      .h_eff         (h_eff),
      .rsp_ready     (rsp_bus.ready),
      .stat          (stat),
      .rsp_valid     (rsp_bus.valid),
      .out_sample    (rsp_bus.out_sample),
      .out_position  (rsp_bus.out_position),
      .last          (rsp_bus.last)
   );

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.last |-> rsp_bus.out_position == {h_eff, 1'b0})
      else $error("last tap at wrong window position");

   a_load_no_issue: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.req_type == twfs_pkg::REQ_LOAD
      |=> !cmd.issue)
      else $error("tap issued after a load item");

   a_shift_blocks: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.req_type == twfs_pkg::REQ_SHIFT
      |=> !req_bus.ready)
      else $error("request taken while a window is in progress");

endmodule

// ===== tb/trace_window_fractional_shift_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trace_window_fractional_shift_top_test: self-checking bench for the shifted,
// interpolated trace window
// Loads trace samples, requests windows under several register settings and
// checks every tap against an in-bench predictor, with random bursts on the
// request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module trace_window_fractional_shift_top_test;

   typedef struct {
      logic                                 req_type;
      logic [twfs_pkg::IDX_W-1:0]           index;
      logic signed [twfs_pkg::SAMPLE_W-1:0] value;
      logic signed [twfs_pkg::SHIFT_W-1:0]  shift;
   } trace_item_type;

   typedef struct {
      logic signed [twfs_pkg::SAMPLE_W-1:0] sample;
      logic [twfs_pkg::POS_W-1:0]           pos;
      logic                                 last;
   } window_tap_type;

   typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_BURSTY} ready_mode_type;

   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 8;
   localparam int ITEM_TARGET    = 370;
   localparam int MAX_PRINTED    = 40;

   localparam logic signed [twfs_pkg::SHIFT_W-1:0] CORNER_SHIFTS [14] = '{
      16'sd0, 16'sd1, -16'sd1, 16'sd127, -16'sd127, 16'sd128, -16'sd128,
      16'sd129, -16'sd129, 16'sd1892, -16'sd1892, -16'sd896, 16'sh7FFF, 16'sh8000
   };

   logic clock;
   logic reset;

   twfs_req_if req_ch();
   twfs_rsp_if rsp_ch();
   twfs_csr_if csr_ch();

   trace_window_fractional_shift_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   // predictor state
   logic signed [twfs_pkg::SAMPLE_W-1:0] trace_shadow [twfs_pkg::DEF_MAX_TRACE];
   bit                                   sample_written [twfs_pkg::DEF_MAX_TRACE];
   logic [twfs_pkg::LEN_W-1:0]           cfg_length = twfs_pkg::RST_TRACE_LENGTH;
   logic [twfs_pkg::CTR_W-1:0]           cfg_center = twfs_pkg::RST_WINDOW_CENTER;
   logic [twfs_pkg::HALF_W-1:0]          cfg_half   = twfs_pkg::RST_HALF_WINDOW;

   trace_item_type pending_items [$];
   window_tap_type taps_due [$];

   int error_count   = 0;
   int items_queued  = 0;
   int loads_sent    = 0;
   int windows_sent  = 0;
   int taps_checked  = 0;
   int settings_used = 0;
   int hold_requests = 0;

   // driver state
   trace_item_type on_bus;
   logic           offer;
   int             burst_left = 1;
   int             gap_left   = 0;

   // monitor state
   window_tap_type got_tap;
   logic           take;
   ready_mode_type ready_mode  = RDY_ALWAYS;
   int             mode_left   = 0;
   int             stall_left  = 0;
   int             hold_left   = 0;
   int             hold_served = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic int eff_length();
      return (int'(cfg_length) > twfs_pkg::DEF_MAX_TRACE)
             ? twfs_pkg::DEF_MAX_TRACE : int'(cfg_length);
   endfunction

   function automatic int eff_half();
      return (int'(cfg_half) > twfs_pkg::DEF_MAX_HALF_WINDOW)
             ? twfs_pkg::DEF_MAX_HALF_WINDOW : int'(cfg_half);
   endfunction

   // Q8.8 shift -> whole offset (half away from zero), neighbor direction, weight
   function automatic void split_shift(input logic signed [twfs_pkg::SHIFT_W-1:0] shift,
                                       output int whole, output int dir, output int frac);
      int s;
      int mag;
      int rem;
      s = int'(shift);
      mag = (s < 0) ? -s : s;
      whole = (mag + 128) / 256;
      if (s < 0)
         whole = -whole;
      rem = s - whole * 256;
      dir = (rem > 0) ? 1 : ((rem < 0) ? -1 : 0);
      frac = (rem < 0) ? -rem : rem;
   endfunction

   function automatic void predict_window(input logic signed [twfs_pkg::SHIFT_W-1:0] shift);
      int whole;
      int dir;
      int frac;
      int n;
      int h;
      int j;
      int nb;
      int v;
      window_tap_type tap;
      split_shift(shift, whole, dir, frac);
      n = eff_length();
      h = eff_half();
      for (int k = 0; k <= 2 * h; k++) begin
         j = int'(cfg_center) - h + whole + k;
         nb = j + dir;
         if (j < 0 || j >= n)
            v = 0;
         else if (dir == 0 || nb < 0 || nb >= n)
            v = int'(trace_shadow[j]);
         else
            v = ((256 - frac) * int'(trace_shadow[j]) + frac * int'(trace_shadow[nb])) >>> 8;
         tap.sample = v[twfs_pkg::SAMPLE_W-1:0];
         tap.pos    = k[twfs_pkg::POS_W-1:0];
         tap.last   = (k == 2 * h);
         taps_due.push_back(tap);
      end
   endfunction

   function automatic void apply_item(input trace_item_type item);
      if (item.req_type == twfs_pkg::REQ_LOAD) begin
         trace_shadow[item.index] = item.value;
         loads_sent++;
      end else begin
         predict_window(item.shift);
         windows_sent++;
      end
   endfunction

   function automatic logic signed [twfs_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sd0;
         3: return -16'sd1;
         default: return twfs_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic queue_load(input int idx,
                             input logic signed [twfs_pkg::SAMPLE_W-1:0] value);
      trace_item_type item;
      item.req_type = twfs_pkg::REQ_LOAD;
      item.index    = idx[twfs_pkg::IDX_W-1:0];
      item.value    = value;
      item.shift    = twfs_pkg::SHIFT_W'($urandom);
      pending_items.push_back(item);
      sample_written[idx] = 1'b1;
      items_queued++;
   endtask

   task automatic fill_entry(input int idx);
      if (!sample_written[idx])
         queue_load(idx, pick_sample());
   endtask

   // entries a window reads must be loaded first
   task automatic queue_shift(input logic signed [twfs_pkg::SHIFT_W-1:0] shift);
      int whole;
      int dir;
      int frac;
      int n;
      int h;
      int j;
      trace_item_type item;
      split_shift(shift, whole, dir, frac);
      n = eff_length();
      h = eff_half();
      for (int k = 0; k <= 2 * h; k++) begin
         j = int'(cfg_center) - h + whole + k;
         if (j >= 0 && j < n) begin
            fill_entry(j);
            if (dir != 0 && j + dir >= 0 && j + dir < n)
               fill_entry(j + dir);
         end
      end
      item.req_type = twfs_pkg::REQ_SHIFT;
      item.index    = twfs_pkg::IDX_W'($urandom);
      item.value    = twfs_pkg::SAMPLE_W'($urandom);
      item.shift    = shift;
      pending_items.push_back(item);
      items_queued++;
   endtask

   task automatic random_items(input int count);
      int h;
      int whole;
      logic signed [twfs_pkg::SHIFT_W-1:0] shift;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 3) begin
            queue_load(int'($urandom_range(0, twfs_pkg::DEF_MAX_TRACE - 1)), pick_sample());
         end else begin
            h = eff_half();
            whole = int'($urandom_range(0, 2 * h + 24)) - (h + 12);
            case ($urandom_range(0, 9))
               0: shift = twfs_pkg::SHIFT_W'($urandom);
               1: shift = twfs_pkg::SHIFT_W'(whole * 256);
               2: shift = twfs_pkg::SHIFT_W'(whole * 256
                          + (($urandom_range(0, 1) == 1) ? 128 : -128));
               default: shift = twfs_pkg::SHIFT_W'(whole * 256
                                + int'($urandom_range(0, 510)) - 255);
            endcase
            queue_shift(shift);
         end
      end
   endtask

   task automatic write_register(input logic [twfs_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [twfs_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         twfs_pkg::REG_TRACE_LENGTH:  cfg_length = value;
         twfs_pkg::REG_WINDOW_CENTER: cfg_center = value[twfs_pkg::CTR_W-1:0];
         twfs_pkg::REG_HALF_WINDOW:   cfg_half   = value[twfs_pkg::HALF_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [twfs_pkg::LEN_W-1:0] len,
                                input logic [twfs_pkg::CTR_W-1:0] center,
                                input logic [twfs_pkg::HALF_W-1:0] half);
      write_register(twfs_pkg::REG_TRACE_LENGTH, len);
      write_register(twfs_pkg::REG_WINDOW_CENTER, twfs_pkg::CSR_DATA_W'(center));
      write_register(twfs_pkg::REG_HALF_WINDOW, twfs_pkg::CSR_DATA_W'(half));
      settings_used++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || taps_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // request driver: bursts of random length, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         offer = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            apply_item(on_bus);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               on_bus = pending_items.pop_front();
               req_ch.req_type     <= on_bus.req_type;
               req_ch.sample_index <= on_bus.index;
               req_ch.sample_value <= on_bus.value;
               req_ch.shift_amount <= on_bus.shift;
               offer = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_ch.valid <= offer;
      end
   end

   // response monitor and stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (taps_due.size() == 0) begin
               report_mismatch($sformatf("unexpected tap pos %0d sample %0d last %0b",
                                         rsp_ch.out_position, rsp_ch.out_sample, rsp_ch.last));
            end else begin
               got_tap = taps_due.pop_front();
               taps_checked++;
               if (rsp_ch.out_sample !== got_tap.sample)
                  report_mismatch($sformatf("pos %0d sample %0d, want %0d", got_tap.pos,
                                            rsp_ch.out_sample, got_tap.sample));
               if (rsp_ch.out_position !== got_tap.pos)
                  report_mismatch($sformatf("position %0d, want %0d",
                                            rsp_ch.out_position, got_tap.pos));
               if (rsp_ch.last !== got_tap.last)
                  report_mismatch($sformatf("pos %0d last %0b, want %0b", got_tap.pos,
                                            rsp_ch.last, got_tap.last));
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLDOFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 2));
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (ready_mode)
               RDY_ALWAYS: take = 1'b1;
               RDY_COIN:   take = 1'($urandom_range(0, 1));
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     take = 1'b0;
                  end else begin
                     take = 1'b1;
                     if ($urandom_range(0, 9) == 0)
                        stall_left = $urandom_range(1, 16);
                  end
               end
            endcase
         end
         rsp_ch.ready <= take;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = twfs_pkg::REQ_LOAD;
      req_ch.sample_index = '0;
      req_ch.sample_value = '0;
      req_ch.shift_amount = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = twfs_pkg::REG_TRACE_LENGTH;
      csr_ch.data         = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: short trace, extreme samples at both ends, corner shifts
      set_registers(9'd16, 8'd8, 5'd3);
      queue_load(0, 16'sh8000);
      queue_load(1, 16'sh7FFF);
      queue_load(14, 16'sh8000);
      queue_load(15, 16'sh7FFF);
      queue_load(twfs_pkg::DEF_MAX_TRACE - 1, -16'sd1);
      foreach (CORNER_SHIFTS[i])
         queue_shift(CORNER_SHIFTS[i]);
      wait_idle();

      // empty trace, length past the store, single tap, single sample
      set_registers(9'd0, 8'd0, 5'd31);
      random_items(6);
      wait_idle();
      set_registers(9'd511, 8'd255, 5'd31);
      random_items(10);
      wait_idle();
      set_registers(9'd256, 8'd0, 5'd0);
      random_items(10);
      wait_idle();
      set_registers(9'd1, 8'd0, 5'd31);
      random_items(8);
      wait_idle();

      // receiver holds off while requests keep coming
      set_registers(9'd256, 8'd127, 5'd15);
      random_items(60);
      hold_requests++;
      wait_idle();

      while (items_queued < ITEM_TARGET) begin
         case ($urandom_range(0, 7))
            0: set_registers(9'd0, twfs_pkg::CTR_W'($urandom),
                             twfs_pkg::HALF_W'($urandom));
            1: set_registers(twfs_pkg::LEN_W'($urandom_range(257, 511)),
                             twfs_pkg::CTR_W'($urandom), twfs_pkg::HALF_W'($urandom));
            default: set_registers(twfs_pkg::LEN_W'($urandom_range(1, 256)),
                                   twfs_pkg::CTR_W'($urandom),
                                   twfs_pkg::HALF_W'($urandom));
         endcase
         random_items(int'($urandom_range(30, 60)));
         wait_idle();
      end

      $display("Covered %0d loads and %0d windows, %0d taps checked, over %0d register settings.",
               loads_sent, windows_sent, taps_checked, settings_used);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d taps outstanding.", taps_due.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
